[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// check that holds in the cycle after reset is applied
`define ASSERT_AFTER_RESET(label, clk, rst, post) \
  label: assert property (@(posedge clk) (rst) |=> (post)) \
    else $error("assertion failed: reset check");

`endif

[hw/rtl/mpp_pkg.sv]
`default_nettype none

package mpp_pkg;

  localparam int CHANNELS = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_W = 12;
  localparam int HEIGHT_W = 16;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd2048;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'hFFFF;

  typedef logic [7:0] channel_t;
  // lane 0 is blue, lane 1 green, lane 2 red
  typedef logic [CHANNELS-1:0][7:0] pixel_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_index_t;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;

  typedef struct packed {
    channel_t res;   // residual or reconstruction
    channel_t orig;  // original pixel byte for the neighbor history
  } lane_out_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/mpp_lane.sv]
`default_nettype none

module mpp_lane (
  input  mpp_pkg::channel_t  sample,
  input  mpp_pkg::channel_t  left,
  input  mpp_pkg::channel_t  above,
  input  mpp_pkg::channel_t  upper_left,
  input  logic               edge_px,
  input  logic               direction,
  output mpp_pkg::lane_out_t lane_out
);
  import mpp_pkg::*;

  channel_t hi;
  channel_t lo;
  channel_t pred;
  channel_t sum;

  always_comb begin
    hi = (left > above) ? left : above;
    lo = (left > above) ? above : left;
    if (upper_left >= hi) begin
      pred = lo;
    end else if (upper_left <= lo) begin
      pred = hi;
    end else begin
      // gradient case stays between lo and hi, so eight bits suffice
      pred = left + above - upper_left;
    end

    if (direction == DIR_INVERSE) begin
      sum = sample + pred;
    end else begin
      sum = sample - pred;
    end

    if (edge_px) begin
      lane_out.res  = sample;
      lane_out.orig = sample;
    end else begin
      lane_out.res  = sum;
      lane_out.orig = (direction == DIR_INVERSE) ? sum : sample;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mpp_line_store.sv]
`default_nettype none

module mpp_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            wen,
  input  logic [AW-1:0]   waddr,
  input  mpp_pkg::pixel_t wdata,
  input  logic [AW-1:0]   raddr,
  output mpp_pkg::pixel_t rdata
);
  import mpp_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t mem_q;
  pixel_t fwd_data;
  logic   fwd_sel;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q    <= mem[raddr];
    // read and write of the same column in one cycle returns the new word
    fwd_sel  <= wen && (waddr == raddr);
    fwd_data <= wdata;
  end

  assign rdata = fwd_sel ? fwd_data : mem_q;

endmodule

`default_nettype wire

[hw/rtl/mpp_merge.sv]
`default_nettype none

module mpp_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  mpp_pkg::lane_out_t [2:0]      lane_res,
  input  logic                          last_px,
  input  logic                          out_ready,
  output logic                          out_valid,
  output mpp_pkg::result_t              out_word,
  output logic                          in_ready
);
  import mpp_pkg::*;

  result_t word_in;
  result_t skid;
  logic    skid_valid;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      word_in.pix[i] = lane_res[i].res;
    end
    word_in.frame_end = last_px;
  end

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word   <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_word  <= word_in;
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      // output is stalled, park the new word
      skid       <= word_in;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/med_pixel_predictor_core.sv]
// MED pixel predictor for a BGR raster stream.
// Input channel: in_valid/in_ready with sample_blue/green/red, one pixel per
// word in raster order. Output channel: out_valid/out_ready with out_blue/
// green/red and frame_end, which marks the last pixel of the frame.
// Configuration: cfg_wen writes cfg_wdata to the register at cfg_index
// (0 direction, 1 image_width, 2 image_height) in the same cycle.
// The output is registered: an accepted word goes to the output register, or to
// the skid word when the output stalls. Throughput is one pixel per cycle while
// in_ready is high, set by the left-neighbor loop (predict and add in the lanes
// feeding the left register) and the single line store read port, read a column ahead.
// Reset clears the raster counters, the output stage and the registers to
// forward mode, width 2048 and height 65535; no clearing pass is needed.
// When the receiver stalls, the output holds and a skid word absorbs one more
// pixel; in_ready then drops until the skid word moves to the output.
`default_nettype none

module med_pixel_predictor_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  mpp_pkg::cfg_index_t  cfg_index,
  input  mpp_pkg::cfg_data_t   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpp_pkg::channel_t    sample_blue,
  input  mpp_pkg::channel_t    sample_green,
  input  mpp_pkg::channel_t    sample_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpp_pkg::channel_t    out_blue,
  output mpp_pkg::channel_t    out_green,
  output mpp_pkg::channel_t    out_red,
  output logic                 frame_end
);
  import mpp_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WC = ((CW + 1) > WIDTH_W) ? (CW + 1) : WIDTH_W;
  localparam logic [WC-1:0] MAX_LAST = WC'(MAX_WIDTH - 1);

  logic                direction;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  logic [CW-1:0]       column_count;
  logic [HEIGHT_W-1:0] row_count;
  pixel_t              left_pixel;
  pixel_t              upper_left_pixel;

  logic                in_fire;
  logic [WIDTH_W-1:0]  width_eff;
  logic [WC-1:0]       last_w;
  logic [WC-1:0]       last_col;
  logic [HEIGHT_W-1:0] height_eff;
  logic                col_wrap;
  logic                row_wrap;
  logic                edge_px;
  logic [CW-1:0]       column_count_next;
  logic [HEIGHT_W-1:0] row_count_next;
  logic [CW-1:0]       rd_addr;

  pixel_t              sample;
  pixel_t              above;
  pixel_t              orig;
  lane_out_t [2:0]     lane_res;
  result_t             out_word;

  assign in_fire = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_FORWARD;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DIRECTION: direction    <= cfg_wdata[0];
        REG_WIDTH:     image_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_HEIGHT:    image_height <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero acts as one, width saturates at the line store depth
    width_eff  = (image_width == '0) ? WIDTH_W'(1) : image_width;
    height_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    last_w     = WC'(width_eff) - WC'(1);
    last_col   = (last_w > MAX_LAST) ? MAX_LAST : last_w;
    col_wrap   = WC'(column_count) >= last_col;
    row_wrap   = row_count >= (height_eff - HEIGHT_W'(1));
    edge_px    = (column_count == '0) || (row_count == '0);

    if (col_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : row_count + HEIGHT_W'(1);
    end else begin
      column_count_next = column_count + CW'(1);
      row_count_next    = row_count;
    end

    // read one column ahead so the above pixel is ready when the word arrives
    rd_addr = in_fire ? column_count_next : column_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (in_fire) begin
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      left_pixel       <= orig;
      upper_left_pixel <= above;
    end
  end

  mpp_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .wen   (in_fire),
    .waddr (column_count),
    .wdata (orig),
    .raddr (rd_addr),
    .rdata (above)
  );

  assign sample[0] = sample_blue;
  assign sample[1] = sample_green;
  assign sample[2] = sample_red;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    mpp_lane u_lane (
      .sample     (sample[i]),
      .left       (left_pixel[i]),
      .above      (above[i]),
      .upper_left (upper_left_pixel[i]),
      .edge_px    (edge_px),
      .direction  (direction),
      .lane_out   (lane_res[i])
    );
    assign orig[i] = lane_res[i].orig;
  end

  mpp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .lane_res  (lane_res),
    .last_px   (col_wrap & row_wrap),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .in_ready  (in_ready)
  );

  assign out_blue  = out_word.pix[0];
  assign out_green = out_word.pix[1];
  assign out_red   = out_word.pix[2];
  assign frame_end = out_word.frame_end;

endmodule

`default_nettype wire

[hw/rtl/mpp_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module mpp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mpp_pkg::channel_t out_blue,
  input mpp_pkg::channel_t out_green,
  input mpp_pkg::channel_t out_red,
  input logic              frame_end
);

  logic [24:0] out_bits;

  assign out_bits = {out_red, out_green, out_blue, frame_end};

  // a stalled word stays on the output unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_bits))

  // output stage is empty after reset
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !out_valid)

  // with nothing on the output the skid word is empty, so input is open
  `ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // no word appears without an accepted pixel
  `ASSERT_NEXT(a_no_spurious, clk, rst, !out_valid && !in_valid, !out_valid)

endmodule

bind med_pixel_predictor_core mpp_checker u_mpp_checker (.*);

`default_nettype wire
